/* rtl/core/sitd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sitd_pkg;

	// fixed widths of the ports and registers
	localparam int NUM_W  = 32;
	localparam int SYM_W  = 8;
	localparam int LEN_W  = 5;
	localparam int CFG_W  = 64;
	localparam int NUM_SYMBOLS = 16;
	localparam int IDX_REG_W   = 2;

	// defaults for the top level parameters
	localparam int MAX_BASE_DEF     = 16;
	localparam int NUMBER_WIDTH_DEF = 32;

	localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'd43;
	localparam logic [SYM_W-1:0] CHAR_MINUS = 8'd45;

	typedef enum logic [IDX_REG_W-1:0] {
		REG_BASE_LENGTH  = 2'd0,
		REG_SYMBOLS_LOW  = 2'd1,
		REG_SYMBOLS_HIGH = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [LEN_W-1:0]                        base_length;
		logic [NUM_SYMBOLS-1:0][SYM_W-1:0]       symbols;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/core/sitd_num_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sitd_num_if;
	import sitd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [NUM_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

`default_nettype wire

/* rtl/core/sitd_sym_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sitd_sym_if;
	import sitd_pkg::*;

	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/sitd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module sitd_queue #(
	parameter int WIDTH = sitd_pkg::NUMBER_WIDTH_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);
	import sitd_pkg::*;

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

`default_nettype wire

/* rtl/core/sitd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sitd_front #(
	parameter int MAX_BASE     = sitd_pkg::MAX_BASE_DEF,
	parameter int NUMBER_WIDTH = sitd_pkg::NUMBER_WIDTH_DEF
) (
	input  sitd_pkg::cfg_t          cfg,
	sitd_num_if.sink                num,
	input  logic                    q_full,
	output logic                    q_push,
	output logic [NUMBER_WIDTH:0]   q_data
);
	import sitd_pkg::*;

	localparam int W = NUMBER_WIDTH;

	logic         base_ok;
	logic         neg;
	logic [W-1:0] raw;
	logic [W-1:0] mag;

	// base must be 2 to MAX_BASE symbols long, hold no sign symbols and no repeats
	always_comb begin
		base_ok = (cfg.base_length >= LEN_W'(2)) && (cfg.base_length <= LEN_W'(MAX_BASE));
		for (int i = 0; i < NUM_SYMBOLS; i++) begin
			if (LEN_W'(i) < cfg.base_length) begin
				if (cfg.symbols[i] == CHAR_PLUS || cfg.symbols[i] == CHAR_MINUS)
					base_ok = 1'b0;
				for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
					if (LEN_W'(j) < cfg.base_length && cfg.symbols[j] == cfg.symbols[i])
						base_ok = 1'b0;
				end
			end
		end
	end

	assign raw = num.number[W-1:0];
	assign neg = raw[W-1];
	// most negative value wraps to 2^(W-1), which still fits unsigned
	assign mag = neg ? (~raw + W'(1)) : raw;

	assign num.ready = !q_full;
	// invalid base: the transaction is taken and dropped
	assign q_push    = num.valid && !q_full && base_ok;
	assign q_data    = {neg, mag};

endmodule

`default_nettype wire

/* rtl/core/sitd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sitd_back #(
	parameter int MAX_BASE     = sitd_pkg::MAX_BASE_DEF,
	parameter int NUMBER_WIDTH = sitd_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sitd_pkg::cfg_t        cfg,
	input  logic                  q_valid,
	input  logic [NUMBER_WIDTH:0] q_data,
	output logic                  q_pop,
	sitd_sym_if.source            sym
);
	import sitd_pkg::*;

	localparam int W     = NUMBER_WIDTH;
	localparam int DIG_W = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
	localparam int DW1   = DIG_W + 1;
	localparam int IDX_W = $clog2(W);
	localparam int NC_W  = $clog2(W + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic               neg_q;
	logic [NC_W-1:0]    ndig_q;
	logic [NC_W-1:0]    ndig_next;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   bit_q;
	logic               out_valid_q;
	logic [SYM_W-1:0]   symbol_q;
	logic               last_q;
	logic [W-1:0]       mag_q;
	logic [DIG_W-1:0]   digits_q  [W];
	logic [DIG_W-1:0]   digits_nx [W];
	logic [W:0]         carry;
	logic [DW1-1:0]     len_d;
	logic               slot_free;
	logic               emit_fire;

	assign len_d     = cfg.base_length[DW1-1:0];
	assign slot_free = !out_valid_q || sym.ready;
	assign emit_fire = slot_free && (state_q == ST_SIGN || state_q == ST_EMIT);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	assign sym.valid  = out_valid_q;
	assign sym.symbol = symbol_q;
	assign sym.last   = last_q;

	// digits = 2 * digits + next magnitude bit, in the configured base;
	// carry per digit is generate/propagate, like an adder carry chain
	always_comb begin
		logic [DW1-1:0] dbl;
		dbl      = '0;
		carry[0] = mag_q[W-1];
		for (int k = 0; k < W; k++) begin
			dbl          = {digits_q[k], 1'b0};
			carry[k+1]   = (dbl >= len_d) || (((dbl | DW1'(1)) == len_d) && carry[k]);
			digits_nx[k] = DIG_W'((dbl | DW1'(carry[k])) - (carry[k+1] ? len_d : '0));
		end
	end

	// digit count grows by one when the top digit carries out
	assign ndig_next = ndig_q + NC_W'(carry[ndig_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_q       <= 1'b0;
			ndig_q      <= '0;
			idx_q       <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
			symbol_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (sym.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						neg_q   <= q_data[W];
						ndig_q  <= NC_W'(1);
						bit_q   <= IDX_W'(W - 1);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					ndig_q <= ndig_next;
					bit_q  <= bit_q - IDX_W'(1);
					if (bit_q == '0) begin
						idx_q   <= IDX_W'(ndig_next - NC_W'(1));
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						symbol_q    <= CHAR_MINUS;
						last_q      <= 1'b0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						symbol_q    <= cfg.symbols[4'(digits_q[idx_q])];
						last_q      <= (idx_q == '0);
						if (idx_q == '0)
							state_q <= ST_IDLE;
						else
							idx_q <= idx_q - IDX_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mag_q    <= q_data[W-1:0];
			digits_q <= '{default: '0};
		end else if (state_q == ST_CONV) begin
			mag_q    <= {mag_q[W-2:0], 1'b0};
			digits_q <= digits_nx;
		end
	end

	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> NC_W'(idx_q) < ndig_q)
		else $error("emit index beyond digit count");

	a_ndig_max: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= NC_W'(W))
		else $error("digit count overflow");

	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SIGN |-> neg_q)
		else $error("minus sign for non-negative number");

	a_pop_conv: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_CONV && ndig_q == NC_W'(1))
		else $error("conversion did not start after pop");

endmodule

`default_nettype wire

/* rtl/core/signed_int_to_radix_digits.sv */
`timescale 1ns / 1ps
`default_nettype none

// on its way to the first symbol a number passes the queue, the ST_CONV conversion and the symbol register
// the back end takes one number at a time: bit-serial base conversion,
// one magnitude bit per cycle, then one symbol per cycle out while the
// receiver is ready, with '-' first for a negative number
// a 2-entry queue lets the front take numbers while the back works
// reset clears the config registers (base invalid), the queue and all control state

module signed_int_to_radix_digits #(
	parameter int MAX_BASE     = sitd_pkg::MAX_BASE_DEF,
	parameter int NUMBER_WIDTH = sitd_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sitd_pkg::IDX_REG_W-1:0]    cfg_index,
	input  logic [sitd_pkg::CFG_W-1:0]        cfg_data,
	sitd_num_if.sink                          num,
	sitd_sym_if.source                        sym
);
	import sitd_pkg::*;

	localparam int QW = NUMBER_WIDTH + 1;

	logic [LEN_W-1:0] base_length_q;
	logic [CFG_W-1:0] symbols_low_q;
	logic [CFG_W-1:0] symbols_high_q;
	cfg_t             cfg;

	logic             q_push;
	logic [QW-1:0]    q_push_data;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	logic [QW-1:0]    q_pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_length_q  <= '0;
			symbols_low_q  <= '0;
			symbols_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_LENGTH:  base_length_q  <= cfg_data[LEN_W-1:0];
				REG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data;
				REG_SYMBOLS_HIGH: symbols_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.base_length = base_length_q;
	assign cfg.symbols     = {symbols_high_q, symbols_low_q};

	sitd_front #(
		.MAX_BASE     (MAX_BASE),
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_front (
		.cfg    (cfg),
		.num    (num),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_push_data)
	);

	sitd_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_pop_data)
	);

	sitd_back #(
		.MAX_BASE     (MAX_BASE),
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_data  (q_pop_data),
		.q_pop   (q_pop),
		.sym     (sym)
	);

endmodule

`default_nettype wire

/* bench/sitd_text_checker.sv */
`timescale 1ns / 1ps

module sitd_text_checker import sitd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [IDX_REG_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sitd_num_if                  num_mon,
	sitd_sym_if                  sym_mon,
	output int                   mismatches,
	output int                   pending
);

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} text_sym_t;

	logic [LEN_W-1:0]                  radix_len;
	logic [NUM_SYMBOLS-1:0][SYM_W-1:0] alphabet;
	text_sym_t                         expected_text[$];
	text_sym_t                         head;

	// text of one number in the current alphabet, nothing if the alphabet is unusable
	function automatic void predict_text(input logic signed [NUM_W-1:0] value);
		logic [NUM_W-1:0] magnitude;
		logic [3:0]       digits[$];
		logic [3:0]       digit;
		text_sym_t        item;
		int               i;
		int               j;

		if (radix_len < 2 || radix_len > MAX_BASE_DEF)
			return;
		for (i = 0; i < radix_len; i++) begin
			if (alphabet[i] == CHAR_PLUS || alphabet[i] == CHAR_MINUS)
				return;
			for (j = i + 1; j < radix_len; j++)
				if (alphabet[j] == alphabet[i])
					return;
		end

		// most negative value wraps to 2^31 as unsigned
		magnitude = value[NUM_W-1] ? (NUM_W'(0) - value) : value;
		do begin
			digits.push_back(4'(magnitude % radix_len));
			magnitude = magnitude / radix_len;
		end while (magnitude != 0);

		if (value[NUM_W-1]) begin
			item.symbol = CHAR_MINUS;
			item.last = 1'b0;
			expected_text.push_back(item);
		end
		while (digits.size() > 0) begin
			digit = digits.pop_back();
			item.symbol = alphabet[digit];
			item.last = (digits.size() == 0);
			expected_text.push_back(item);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_len = '0;
			alphabet = '0;
			expected_text.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_LENGTH:  radix_len = cfg_data[LEN_W-1:0];
					REG_SYMBOLS_LOW:  alphabet[7:0] = cfg_data;
					REG_SYMBOLS_HIGH: alphabet[15:8] = cfg_data;
					default: ;
				endcase
			end

			if (sym_mon.valid && sym_mon.ready) begin
				if (expected_text.size() == 0) begin
					$error("symbol %0d arrived with no number waiting", sym_mon.symbol);
					mismatches++;
				end else begin
					head = expected_text.pop_front();
					if (sym_mon.symbol !== head.symbol) begin
						$error("symbol: expected %0d, got %0d", head.symbol, sym_mon.symbol);
						mismatches++;
					end
					if (sym_mon.last !== head.last) begin
						$error("last: expected %0d, got %0d", head.last, sym_mon.last);
						mismatches++;
					end
				end
			end

			if (num_mon.valid && num_mon.ready)
				predict_text(num_mon.number);

			pending = expected_text.size();
		end
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import sitd_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 300;
	localparam int LONG_HOLD    = 600;

	// index with no register behind it
	localparam logic [IDX_REG_W-1:0] REG_UNUSED = 2'd3;

	localparam logic [NUM_SYMBOLS-1:0][SYM_W-1:0] HEX_DIGITS =
		{64'h6665646362613938, 64'h3736353433323130};
	// zero byte as digit 0, sign characters and repeats only past the third symbol
	localparam logic [NUM_SYMBOLS-1:0][SYM_W-1:0] ZERO_BYTE_ALPHA =
		{64'hFFFFFFFFFFFFFFFF, 64'h2D2B2D2B2DFF7F00};

	typedef enum int {SPOIL_PLUS, SPOIL_MINUS, SPOIL_REPEAT} spoil_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IDX_REG_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int mismatch_count;
	int symbols_pending;
	int cycle_count = 0;
	int burst_left = 0;
	int idle_gap;
	int stall_mode = 0;
	int mode_left = 0;
	bit hold_wanted = 1'b0;
	bit hold_done = 1'b0;

	sitd_num_if num_bus ();
	sitd_sym_if sym_bus ();

	signed_int_to_radix_digits uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.num       (num_bus),
		.sym       (sym_bus)
	);

	sitd_text_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.num_mon    (num_bus),
		.sym_mon    (sym_bus),
		.mismatches (mismatch_count),
		.pending    (symbols_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("signed_int_to_radix_digits regression: fail");
			$finish;
		end
	end

	// receiver: stall mode changes at random intervals, one long hold on request
	initial begin
		sym_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted && !hold_done) begin
				sym_bus.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(32, 256);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0:       sym_bus.ready <= 1'b1;
					1:       sym_bus.ready <= $urandom_range(0, 1);
					default: sym_bus.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic logic signed [NUM_W-1:0] rand_number(input int len);
		longint base;
		longint power;
		int     k;

		base = (len < 2) ? 2 : len;
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 300);
			2: return -$signed({1'b0, 31'($urandom_range(1, 300))});
			3: begin
				case ($urandom_range(0, 5))
					0:       return 32'sh80000000;
					1:       return 32'sh7FFFFFFF;
					2:       return -1;
					3:       return 0;
					4:       return 32'sh80000001;
					default: return 32'sh7FFFFFFE;
				endcase
			end
			default: begin
				// near a power of the base, where the digit count steps
				power = 1;
				k = $urandom_range(1, 31);
				repeat (k)
					if (power * base <= 64'd2147483648)
						power = power * base;
				power = power + $urandom_range(0, 2) - 1;
				return $urandom_range(0, 1) ? -NUM_W'(power) : NUM_W'(power);
			end
		endcase
	endfunction

	function automatic logic [NUM_SYMBOLS-1:0][SYM_W-1:0] make_alphabet(input int len);
		logic [NUM_SYMBOLS-1:0][SYM_W-1:0] alpha;
		logic [SYM_W-1:0]                  pick;
		bit                                clash;
		int                                i;
		int                                j;

		for (i = 0; i < NUM_SYMBOLS; i++) begin
			if (i >= len) begin
				alpha[i] = $urandom_range(0, 255);
			end else begin
				do begin
					pick = $urandom_range(0, 255);
					clash = (pick == CHAR_PLUS) || (pick == CHAR_MINUS);
					for (j = 0; j < i; j++)
						if (alpha[j] == pick)
							clash = 1'b1;
				end while (clash);
				alpha[i] = pick;
			end
		end
		return alpha;
	endfunction

	function automatic logic [NUM_SYMBOLS-1:0][SYM_W-1:0] spoil_alphabet(
		input logic [NUM_SYMBOLS-1:0][SYM_W-1:0] alpha,
		input int len,
		input spoil_t how
	);
		int i;
		int j;

		i = $urandom_range(0, len - 2);
		j = $urandom_range(i + 1, len - 1);
		case (how)
			SPOIL_PLUS:  alpha[j] = CHAR_PLUS;
			SPOIL_MINUS: alpha[i] = CHAR_MINUS;
			default:     alpha[j] = alpha[i];
		endcase
		return alpha;
	endfunction

	task automatic write_reg(input logic [IDX_REG_W-1:0] index, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic program_alphabet(input int len,
		input logic [NUM_SYMBOLS-1:0][SYM_W-1:0] alpha);
		logic [CFG_W-1:0] len_word;

		// bits above the length field are don't care, so fill them with noise
		len_word = {$urandom, $urandom};
		len_word[LEN_W-1:0] = len[LEN_W-1:0];
		write_reg(REG_BASE_LENGTH, len_word);
		write_reg(REG_SYMBOLS_LOW, alpha[7:0]);
		write_reg(REG_SYMBOLS_HIGH, alpha[15:8]);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	// one number transaction, then maybe an idle gap between bursts
	task automatic offer(input logic signed [NUM_W-1:0] value);
		num_bus.valid <= 1'b1;
		num_bus.number <= value;
		@(posedge clk);
		while (!num_bus.ready)
			@(posedge clk);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			idle_gap = $urandom_range(1, 6);
			num_bus.valid <= 1'b0;
			repeat (idle_gap) @(negedge clk);
		end
	endtask

	task automatic settle();
		while (symbols_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int len, input logic [NUM_SYMBOLS-1:0][SYM_W-1:0] alpha,
		input bit with_extremes, input bit with_hold, input int count);
		settle();
		program_alphabet(len, alpha);
		if (with_hold)
			hold_wanted <= 1'b1;
		if (with_extremes) begin
			offer(0);
			offer(1);
			offer(-1);
			offer(32'sh7FFFFFFF);
			offer(32'sh80000000);
			offer(len - 1);
			offer(len);
			offer(-(len + 1));
		end
		repeat (count) offer(rand_number(len));
		num_bus.valid <= 1'b0;
	endtask

	initial begin
		int                                k;
		int                                rand_len;
		logic [NUM_SYMBOLS-1:0][SYM_W-1:0] alpha;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BASE_LENGTH;
		cfg_data = '0;
		num_bus.valid = 1'b0;
		num_bus.number = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// base length is zero out of reset, so these give nothing
		repeat (2) offer(rand_number(2));
		num_bus.valid <= 1'b0;

		run_phase(2, HEX_DIGITS, 1'b1, 1'b0, 20);
		run_phase(0, HEX_DIGITS, 1'b0, 1'b0, 3);
		run_phase(16, HEX_DIGITS, 1'b1, 1'b0, 20);
		run_phase(17, HEX_DIGITS, 1'b0, 1'b0, 3);
		run_phase(3, ZERO_BYTE_ALPHA, 1'b1, 1'b0, 20);
		run_phase(10, HEX_DIGITS, 1'b0, 1'b1, 30);

		for (k = 0; k < 10; k++) begin
			rand_len = $urandom_range(2, 16);
			alpha = make_alphabet(rand_len);
			run_phase(rand_len, alpha, 1'b0, 1'b0, 8);
			case (k)
				0: run_phase(1, make_alphabet(16), 1'b0, 1'b0, 3);
				1: run_phase(rand_len, spoil_alphabet(alpha, rand_len, SPOIL_PLUS),
					1'b0, 1'b0, 3);
				2: run_phase(rand_len, spoil_alphabet(alpha, rand_len, SPOIL_MINUS),
					1'b0, 1'b0, 3);
				3: run_phase(16, spoil_alphabet(make_alphabet(16), 16, SPOIL_REPEAT),
					1'b0, 1'b0, 3);
				4: run_phase(31, make_alphabet(16), 1'b0, 1'b0, 3);
				5: run_phase(rand_len, spoil_alphabet(alpha, rand_len, SPOIL_REPEAT),
					1'b0, 1'b0, 3);
				default: ;
			endcase
		end

		settle();
		if (mismatch_count == 0 && symbols_pending == 0)
			$display("signed_int_to_radix_digits regression: pass");
		else
			$display("signed_int_to_radix_digits regression: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/sitd_pkg.sv
rtl/core/sitd_num_if.sv
rtl/core/sitd_sym_if.sv
rtl/core/sitd_queue.sv
rtl/core/sitd_front.sv
rtl/core/sitd_back.sv
rtl/core/signed_int_to_radix_digits.sv
bench/sitd_text_checker.sv
bench/testbench.sv
